// ===== rtl/core/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants of the key matrix PS/2 transmitter
// Holds the command and result formats, the configuration register map,
// the scan code constants and the fixed key code table of the 8x8 matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

    // Stream widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Configuration register map.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_SCANS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_INTERVAL = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  DEBOUNCE_SCANS_RST = 8'd20;
    localparam logic [CFG_DATA_W-1:0]  FRAME_INTERVAL_RST = 8'd40;

    // Depth of the command queue between the front and the engine.
    localparam int CMDQ_DEPTH = 2;

    // Scan code bytes.
    localparam logic [7:0] CODE_BREAK = 8'hF0;
    localparam logic [7:0] CODE_EXT   = 8'hE0;
    localparam logic [7:0] EXT_KEY_A  = 8'h6B;
    localparam logic [7:0] EXT_KEY_B  = 8'h74;

    // Key code table, indexed by row and then column. Zero means no key.
    localparam logic [7:0] KEY_CODE_ROM [8][8] = '{
        '{8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h00, 8'h00},
        '{8'h00, 8'h15, 8'h1D, 8'h24, 8'h2D, 8'h2C, 8'h14, 8'h00},
        '{8'h6B, 8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h00, 8'h00},
        '{8'h00, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32, 8'h00, 8'h59},
        '{8'h3D, 8'h3E, 8'h46, 8'h45, 8'h52, 8'h4E, 8'h00, 8'h00},
        '{8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D, 8'h5A, 8'h00, 8'h00},
        '{8'h33, 8'h3B, 8'h42, 8'h4B, 8'h4C, 8'h74, 8'h00, 8'h00},
        '{8'h31, 8'h3A, 8'h41, 8'h49, 8'h4A, 8'h29, 8'h00, 8'h00}
    };

    // Command kinds after classification.
    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_TICK = 2'd1,
        OP_SKIP = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [2:0] row_index;
        logic [7:0] column_bits;
    } cmd_t;

    typedef struct packed {
        logic [7:0] debounce_scans;
        logic [7:0] frame_interval;
    } cfg_t;

    // Result beat, ps2_clock in the lowest bit.
    typedef struct packed {
        logic       dropped_oldest;
        logic [6:0] queue_level;
        logic       ps2_data;
        logic       ps2_clock;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/kmp_front.sv =====
// ----------------------------------------------------------------------------
// kmp_front: input side of the key matrix PS/2 transmitter
// Accepts input beats, sorts them into scan, tick and skip commands and
// holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_front #(
    parameter int ROWS = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [kmp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]                     s_tuser,
    output logic                                cmd_valid,
    input  wire logic                           cmd_ready,
    output kmp_pkg::cmd_t                       cmd
);

    localparam int CNT_W = $clog2(kmp_pkg::CMDQ_DEPTH + 1);
    localparam int PTR_W = (kmp_pkg::CMDQ_DEPTH > 1) ? $clog2(kmp_pkg::CMDQ_DEPTH) : 1;

    kmp_pkg::cmd_t   in_cmd;
    kmp_pkg::cmd_t   q_reg [kmp_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    // Classify the incoming beat. Rows beyond the matrix are skipped.
    always_comb begin
        in_cmd.row_index   = s_tdata[2:0];
        in_cmd.column_bits = s_tdata[10:3];
        if (s_tuser[0]) begin
            in_cmd.kind = kmp_pkg::OP_TICK;
        end else if (int'(s_tdata[2:0]) < ROWS) begin
            in_cmd.kind = kmp_pkg::OP_SCAN;
        end else begin
            in_cmd.kind = kmp_pkg::OP_SKIP;
        end
    end

    assign s_tready  = (count_reg != CNT_W'(kmp_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(kmp_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(kmp_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kmp_engine.sv =====
// ----------------------------------------------------------------------------
// kmp_engine: execution side of the key matrix PS/2 transmitter
// Runs per-key debounce one column per cycle, pausing while scan code bytes
// are pushed into the code ring one byte per cycle, steps the PS/2 transmit
// frame on ticks and holds the finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_engine #(
    parameter int ROWS       = 8,
    parameter int COLS       = 8,
    parameter int RING_DEPTH = 128
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire kmp_pkg::cfg_t cfg,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire kmp_pkg::cmd_t cmd,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output kmp_pkg::res_t      res
);

    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PW    = $clog2(RING_DEPTH);
    localparam int LW    = (PW > 7) ? PW : 7;
    localparam int ROW_W = COLS * 9;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ROWRD = 8'b0000_0010,
        S_ROWLD = 8'b0000_0100,
        S_COL   = 8'b0000_1000,
        S_PUSH  = 8'b0001_0000,
        S_ROWWR = 8'b0010_0000,
        S_TICK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           row_reg, row_next;
    logic [7:0]           cols_reg, cols_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [COLS-1:0][7:0] row_cnt_reg, row_cnt_next;
    logic [COLS-1:0]      row_open_reg, row_open_next;
    logic [ROWS-1:0]      row_valid_reg, row_valid_next;
    logic [2:0]           pend_reg, pend_next;
    logic [7:0]           code_reg, code_next;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic                 drop_reg, drop_next;
    logic                 clk_reg, clk_next;
    logic                 data_reg, data_next;
    logic [7:0]           step_reg, step_next;
    logic                 par_reg, par_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 out_valid_reg, out_valid_next;
    kmp_pkg::res_t        out_reg, out_next;

    logic                 key_wr_en;
    logic [ROW_W-1:0]     key_rd_data;
    logic                 ring_wr_en;
    logic [7:0]           ring_wr_data;
    logic [7:0]           ring_rd_data;

    logic [7:0]           cur_cnt;
    logic                 cur_open;
    logic                 cur_level;
    logic [7:0]           cur_code;
    logic                 col_last;
    logic                 advance;
    logic [2:0]           pend_left;
    logic [PW-1:0]        tail_inc;
    logic [8:0]           step_wide;
    logic [PW:0]          level_wide;
    logic [LW:0]          level_ext;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Per-row key state: counters and recorded open levels, one word a row.
    kmp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (row_reg[RAW-1:0]),
        .wr_data ({row_open_reg, row_cnt_reg}),
        .rd_addr (row_reg[RAW-1:0]),
        .rd_data (key_rd_data)
    );

    // Scan code ring: written at the tail, read at the head.
    kmp_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ring_wr_data),
        .rd_addr (head_reg),
        .rd_data (ring_rd_data)
    );

    // Current column of the row under scan.
    assign cur_cnt   = row_cnt_reg[col_reg];
    assign cur_open  = row_open_reg[col_reg];
    assign cur_level = cols_reg[col_reg];
    assign cur_code  = kmp_pkg::KEY_CODE_ROM[row_reg][3'(col_reg)];
    assign col_last  = (col_reg == CW'(COLS - 1));

    // Byte to push and the bytes left after it.
    always_comb begin
        if (pend_reg[2]) begin
            ring_wr_data = kmp_pkg::CODE_EXT;
            pend_left    = {1'b0, pend_reg[1:0]};
        end else if (pend_reg[1]) begin
            ring_wr_data = kmp_pkg::CODE_BREAK;
            pend_left    = {2'b00, pend_reg[0]};
        end else begin
            ring_wr_data = code_reg;
            pend_left    = 3'b000;
        end
    end

    assign tail_inc = ring_next(tail_reg);

    // Bytes waiting in the ring, reported modulo 128.
    assign level_wide = (PW+1)'(tail_reg) - (PW+1)'(head_reg)
                      + ((tail_reg < head_reg) ? (PW+1)'(RING_DEPTH) : '0);
    assign level_ext  = (LW+1)'(level_wide);

    assign cmd_ready  = (state_reg == S_IDLE);
    assign key_wr_en  = (state_reg == S_ROWWR);
    assign ring_wr_en = (state_reg == S_PUSH);
    assign m_tvalid   = out_valid_reg;
    assign res        = out_reg;

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        cols_next      = cols_reg;
        col_next       = col_reg;
        row_cnt_next   = row_cnt_reg;
        row_open_next  = row_open_reg;
        row_valid_next = row_valid_reg;
        pend_next      = pend_reg;
        code_next      = code_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        drop_next      = drop_reg;
        clk_next       = clk_reg;
        data_next      = data_reg;
        step_next      = step_reg;
        par_next       = par_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        advance        = 1'b0;
        step_wide      = {1'b0, step_reg};

        // The downstream side takes the held result.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    row_next  = cmd.row_index;
                    cols_next = cmd.column_bits;
                    col_next  = '0;
                    drop_next = 1'b0;
                    case (cmd.kind)
                        kmp_pkg::OP_SCAN: state_next = S_ROWRD;
                        kmp_pkg::OP_TICK: state_next = S_TICK;
                        default:          state_next = S_DONE;
                    endcase
                end
            end

            S_ROWRD: begin
                state_next = S_ROWLD;
            end

            // A row never written back reads as released keys, idle counters.
            S_ROWLD: begin
                if (row_valid_reg[row_reg[RAW-1:0]]) begin
                    {row_open_next, row_cnt_next} = key_rd_data;
                end else begin
                    row_open_next = '1;
                    row_cnt_next  = '0;
                end
                state_next = S_COL;
            end

            // Debounce one key.
            S_COL: begin
                if (cur_cnt > 8'd1) begin
                    row_cnt_next[col_reg] = cur_cnt - 8'd1;
                    advance = 1'b1;
                end else if (cur_cnt == 8'd1) begin
                    row_cnt_next[col_reg] = 8'd0;
                    if ((cur_level == cur_open) && (cur_code != 8'd0)) begin
                        pend_next  = {(cur_code == kmp_pkg::EXT_KEY_A) ||
                                      (cur_code == kmp_pkg::EXT_KEY_B),
                                      cur_level, 1'b1};
                        code_next  = cur_code;
                        state_next = S_PUSH;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    if (cur_level != cur_open) begin
                        row_open_next[col_reg] = cur_level;
                        row_cnt_next[col_reg]  = cfg.debounce_scans;
                    end
                    advance = 1'b1;
                end
            end

            // Push one byte; a full ring loses its oldest byte.
            S_PUSH: begin
                tail_next = tail_inc;
                if (tail_inc == head_reg) begin
                    head_next = ring_next(head_reg);
                    drop_next = 1'b1;
                end
                pend_next = pend_left;
                if (pend_left == 3'b000) begin
                    advance = 1'b1;
                end
            end

            S_ROWWR: begin
                row_valid_next[row_reg[RAW-1:0]] = 1'b1;
                state_next = S_DONE;
            end

            // One half-bit step of the transmit frame.
            S_TICK: begin
                if (!clk_reg) begin
                    clk_next  = 1'b1;
                    step_wide = step_wide + 9'd1;
                end else if (step_wide == 9'd0) begin
                    if (head_reg != tail_reg) begin
                        shift_next = ring_rd_data;
                        head_next  = ring_next(head_reg);
                        data_next  = 1'b0;
                        clk_next   = 1'b0;
                    end
                end else if (step_wide <= 9'd8) begin
                    data_next  = shift_reg[0];
                    par_next   = par_reg ^ shift_reg[0];
                    shift_next = {1'b0, shift_reg[7:1]};
                    clk_next   = 1'b0;
                end else if (step_wide == 9'd9) begin
                    data_next = ~par_reg;
                    clk_next  = 1'b0;
                end else if (step_wide == 9'd10) begin
                    data_next = 1'b1;
                    clk_next  = 1'b0;
                end else begin
                    step_wide = step_wide + 9'd1;
                end
                if (step_wide > {1'b0, cfg.frame_interval}) begin
                    step_wide  = 9'd0;
                    par_next   = 1'b0;
                    shift_next = 8'd0;
                end
                step_next  = step_wide[7:0];
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next          = 1'b1;
                    out_next.ps2_clock      = clk_reg;
                    out_next.ps2_data       = data_reg;
                    out_next.queue_level    = level_ext[6:0];
                    out_next.dropped_oldest = drop_reg;
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Move to the next column or finish the row.
        if (advance) begin
            if (col_last) begin
                state_next = S_ROWWR;
            end else begin
                col_next   = col_reg + 1'b1;
                state_next = S_COL;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            clk_reg       <= 1'b1;
            data_reg      <= 1'b1;
            step_reg      <= 8'd0;
            par_reg       <= 1'b0;
            shift_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            clk_reg       <= clk_next;
            data_reg      <= data_next;
            step_reg      <= step_next;
            par_reg       <= par_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        cols_reg     <= cols_next;
        col_reg      <= col_next;
        row_cnt_reg  <= row_cnt_next;
        row_open_reg <= row_open_next;
        pend_reg     <= pend_next;
        code_reg     <= code_next;
        drop_reg     <= drop_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/key_matrix_ps2_transmitter.sv =====
// ----------------------------------------------------------------------------
// key_matrix_ps2_transmitter: key matrix scanner with PS/2 device output
// Order: a tick steps the frame, a skipped row goes straight to its result,
// a row sample reads its key word, debounces the columns, pushes bytes and
// writes the word back. The engine takes one key column or one ring byte per
// cycle, a new beat only after the last result; a 2-entry queue buffers input.
// Reset: synchronous, active low; ring empty, lines high, all keys released.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_ps2_transmitter #(
    parameter int ROWS       = 8,
    parameter int COLS       = 8,
    parameter int RING_DEPTH = 128
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input beats.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [kmp_pkg::S_TDATA_W-1:0]    s_tdata,   // row_index[2:0], column_bits[10:3]
    input  wire logic [0:0]                       s_tuser,   // func[0]
    // Result beats.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [kmp_pkg::M_TDATA_W-1:0]    m_tdata,   // ps2_clock[0], ps2_data[1],
                                                             // queue_level[8:2], dropped_oldest[9]
    // Configuration writes.
    input  wire logic                             cfg_wr_en,
    input  wire logic [kmp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [kmp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    kmp_pkg::cfg_t cfg_reg, cfg_next;
    kmp_pkg::cmd_t cmd;
    kmp_pkg::res_t res;
    logic          cmd_valid;
    logic          cmd_ready;

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                kmp_pkg::CFG_DEBOUNCE_SCANS: cfg_next.debounce_scans = cfg_wdata;
                kmp_pkg::CFG_FRAME_INTERVAL: cfg_next.frame_interval = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_scans <= kmp_pkg::DEBOUNCE_SCANS_RST;
            cfg_reg.frame_interval <= kmp_pkg::FRAME_INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input side and command queue.
    kmp_front #(
        .ROWS (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Debounce, ring and transmit engine.
    kmp_engine #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .RING_DEPTH (RING_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    assign m_tdata = {(kmp_pkg::M_TDATA_W - $bits(kmp_pkg::res_t))'(0), res};

    // No result is offered in the cycle after reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A dropped byte means the ring was left full.
    a_drop_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (m_tdata[8:2] == 7'(RING_DEPTH - 1)))
        else $error("dropped byte reported with ring not full");

    // The input side only stalls while the queue has a command to offer.
    a_stall_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> cmd_valid)
        else $error("input stalled with an empty command queue");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the key matrix PS/2 transmitter
// Drives row samples and half-bit ticks over the input stream. A behavioral
// model of the debounce logic, the scan code ring and the PS/2 frame
// predicts every result beat, and a scoreboard compares the beats field by
// field. A short directed table comes first. Randomized phases follow, each
// with its own register setting; outside quiet phases both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import kmp_pkg::*;

    localparam bit FUNC_SCAN    = 1'b0;
    localparam bit FUNC_TICK    = 1'b1;
    localparam int RING_SLOTS   = 128;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;

    localparam res_t LINES_IDLE = '{dropped_oldest: 1'b0, queue_level: 7'd0,
                                    ps2_data: 1'b1, ps2_clock: 1'b1};
    localparam res_t SEVEN_QUEUED = '{dropped_oldest: 1'b0, queue_level: 7'd7,
                                      ps2_data: 1'b1, ps2_clock: 1'b1};

    // One row of the opening table; the result is typed in only when flagged.
    typedef struct packed {
        logic       func;
        logic [2:0] row;
        logic [7:0] cols;
        logic       typed;
        res_t       want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Expected result beats, oldest first.
    res_t line_expect_q[$];
    bit   mismatch_seen;
    int   beats_checked;
    bit   no_idle;

    // Model state: registers, per-key debounce, scan code ring, PS/2 frame.
    logic [7:0]  dbs_cfg;
    logic [7:0]  fint_cfg;
    logic [7:0]  scan_cnt [64];
    logic        key_up [64];
    logic [7:0]  code_ring [RING_SLOTS];
    int unsigned ring_rd;
    int unsigned ring_wr;
    logic        line_clk;
    logic        line_dat;
    logic [7:0]  bit_step;
    logic        par_acc;
    logic [7:0]  tx_byte;

    key_matrix_ps2_transmitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void model_reset();
        dbs_cfg  = DEBOUNCE_SCANS_RST;
        fint_cfg = FRAME_INTERVAL_RST;
        for (int k = 0; k < 64; k++) begin
            scan_cnt[k] = 8'd0;
            key_up[k]   = 1'b1;
        end
        ring_rd  = 0;
        ring_wr  = 0;
        line_clk = 1'b1;
        line_dat = 1'b1;
        bit_step = 8'd0;
        par_acc  = 1'b0;
        tx_byte  = 8'd0;
    endfunction

    // Push one byte; a full ring loses its oldest byte.
    function automatic bit ring_put(input logic [7:0] b);
        code_ring[ring_wr] = b;
        ring_wr = (ring_wr + 1) % RING_SLOTS;
        if (ring_wr == ring_rd) begin
            ring_rd = (ring_rd + 1) % RING_SLOTS;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Debounce every column of one row and queue codes of confirmed keys.
    function automatic bit scan_keys(input logic [2:0] r, input logic [7:0] cols);
        bit         lost;
        int         k;
        logic       lvl;
        logic [7:0] code;
        lost = 1'b0;
        for (int c = 0; c < 8; c++) begin
            k    = r * 8 + c;
            lvl  = cols[c];
            code = KEY_CODE_ROM[r][c];
            if (scan_cnt[k] > 8'd1) begin
                scan_cnt[k] = scan_cnt[k] - 8'd1;
            end else if (scan_cnt[k] == 8'd1) begin
                if (lvl == key_up[k] && code != 8'd0) begin
                    if (code == EXT_KEY_A || code == EXT_KEY_B)
                        lost |= ring_put(CODE_EXT);
                    if (lvl)
                        lost |= ring_put(CODE_BREAK);
                    lost |= ring_put(code);
                end
                scan_cnt[k] = 8'd0;
            end else if (lvl != key_up[k]) begin
                key_up[k]   = lvl;
                scan_cnt[k] = dbs_cfg;
            end
        end
        return lost;
    endfunction

    // One half bit of the device-to-host frame.
    function automatic void half_bit_tick();
        int unsigned s;
        s = bit_step;
        if (!line_clk) begin
            line_clk = 1'b1;
            s++;
        end else if (s == 0) begin
            if (ring_rd != ring_wr) begin
                tx_byte  = code_ring[ring_rd];
                ring_rd  = (ring_rd + 1) % RING_SLOTS;
                line_dat = 1'b0;
                line_clk = 1'b0;
            end
        end else if (s <= 8) begin
            line_dat = tx_byte[0];
            par_acc ^= line_dat;
            tx_byte  = tx_byte >> 1;
            line_clk = 1'b0;
        end else if (s == 9) begin
            line_dat = ~par_acc;
            line_clk = 1'b0;
        end else if (s == 10) begin
            line_dat = 1'b1;
            line_clk = 1'b0;
        end else begin
            s++;
        end
        if (s > fint_cfg) begin
            s       = 0;
            par_acc = 1'b0;
            tx_byte = 8'd0;
        end
        bit_step = s[7:0];
    endfunction

    function automatic res_t predict_lines(input logic func, input logic [2:0] r,
                                           input logic [7:0] cols);
        res_t o;
        bit   lost;
        lost = 1'b0;
        if (func == FUNC_SCAN)
            lost = scan_keys(r, cols);
        else
            half_bit_tick();
        o.ps2_clock      = line_clk;
        o.ps2_data       = line_dat;
        o.queue_level    = 7'((ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS);
        o.dropped_oldest = lost;
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat, wait for the handshake and record what it should produce.
    task automatic send_item(input logic func, input logic [2:0] r, input logic [7:0] cols,
                             input logic typed, input res_t typed_res);
        int   gap;
        res_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, cols, r};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        want = predict_lines(func, r, cols);
        if (typed)
            want = typed_res;
        line_expect_q.push_back(want);
    endtask

    // Register writes happen only once every outstanding result is back.
    task automatic write_regs(input logic [7:0] dbs, input logic [7:0] fint);
        s_tvalid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_SCANS;
        cfg_wdata <= dbs;
        @(posedge aclk);
        cfg_index <= CFG_FRAME_INTERVAL;
        cfg_wdata <= fint;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dbs_cfg  = dbs;
        fint_cfg = fint;
    endtask

    // Random phase: key changes held through the debounce window,
    // tick bursts to drain the ring, and some bouncing noise.
    task automatic run_phase(input logic [7:0] dbs, input logic [7:0] fint,
                             input int tick_pct, input int budget, input bit quiet);
        int         sent;
        int         pick;
        int         reps;
        logic [2:0] r;
        logic [7:0] mask;
        write_regs(dbs, fint);
        no_idle = quiet;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            r    = 3'($urandom_range(0, 7));
            if (pick < tick_pct) begin
                reps = $urandom_range(1, 24);
                repeat (reps)
                    send_item(FUNC_TICK, 3'($urandom_range(0, 7)), 8'($urandom),
                              1'b0, LINES_IDLE);
                sent += reps;
            end else if (pick < 88) begin
                for (int c = 0; c < 8; c++)
                    mask[c] = key_up[r * 8 + c];
                if ($urandom_range(0, 4) == 0)
                    mask = ~mask;
                else
                    mask ^= 8'($urandom) & 8'($urandom);
                reps = int'(dbs_cfg) + 1 + $urandom_range(0, 1);
                repeat (reps) begin
                    if (tick_pct > 0 && $urandom_range(0, 4) == 0) begin
                        send_item(FUNC_TICK, r, mask, 1'b0, LINES_IDLE);
                        sent++;
                    end
                    send_item(FUNC_SCAN, r, mask, 1'b0, LINES_IDLE);
                end
                sent += reps;
            end else begin
                reps = $urandom_range(1, 3);
                repeat (reps)
                    send_item(FUNC_SCAN, r, 8'($urandom), 1'b0, LINES_IDLE);
                sent += reps;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off while the sender keeps going.
    initial begin
        int n;
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && beats_checked >= 100) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            n = $urandom_range(0, 99);
            if (no_idle || n < 65)
                n = 0;
            else if (n < 93)
                n = $urandom_range(1, 4);
            else
                n = $urandom_range(20, 80);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // Scoreboard: every accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (line_expect_q.size() == 0) begin
                $error("result beat with nothing expected: m_tdata=%h", m_tdata);
                mismatch_seen = 1'b1;
            end else begin
                want = line_expect_q.pop_front();
                check_field("ps2_clock", 8'(want.ps2_clock), 8'(got.ps2_clock));
                check_field("ps2_data", 8'(want.ps2_data), 8'(got.ps2_data));
                check_field("queue_level", 8'(want.queue_level), 8'(got.queue_level));
                check_field("dropped_oldest", 8'(want.dropped_oldest),
                            8'(got.dropped_oldest));
            end
            beats_checked++;
        end
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        stim_row_t opening_rows [0:24];
        // Reset state, presses and releases (with both extended keys), keys
        // without a code, a bounce before confirmation, then a frame start.
        opening_rows = '{
            '{FUNC_TICK, 3'd0, 8'h00, 1'b1, LINES_IDLE},
            '{FUNC_SCAN, 3'd0, 8'hFF, 1'b1, LINES_IDLE},
            '{FUNC_SCAN, 3'd2, 8'h00, 1'b1, LINES_IDLE},
            '{FUNC_SCAN, 3'd2, 8'h00, 1'b1, SEVEN_QUEUED},
            '{FUNC_TICK, 3'd7, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd7, 8'h00, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd7, 8'h00, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd6, 8'hDF, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd6, 8'hDF, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd2, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd2, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd3, 8'h7E, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd3, 8'h7E, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd0, 8'h00, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd0, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_SCAN, 3'd0, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd7, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd0, 8'h00, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd5, 8'hAA, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd2, 8'h55, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd7, 8'hFF, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd0, 8'h00, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd1, 8'h0F, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd6, 8'hF0, 1'b0, LINES_IDLE},
            '{FUNC_TICK, 3'd3, 8'h81, 1'b0, LINES_IDLE}
        };

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        mismatch_seen = 1'b0;
        beats_checked = 0;
        no_idle       = 1'b0;
        model_reset();

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Opening table with one-scan debounce so that changes confirm on the row's next scan.
        write_regs(8'd1, FRAME_INTERVAL_RST);
        foreach (opening_rows[i])
            send_item(opening_rows[i].func, opening_rows[i].row, opening_rows[i].cols,
                      opening_rows[i].typed, opening_rows[i].want);

        // Register settings, extremes included: shortest frame, a flood that
        // overruns the ring, zero debounce, a frame cut short, longest
        // debounce and interval, the reset values and a draining phase.
        run_phase(8'd1,   8'd11,  45, 150, 1'b1);
        run_phase(8'd1,   8'd255, 0,  150, 1'b0);
        run_phase(8'd0,   8'd20,  40, 80,  1'b0);
        run_phase(8'd3,   8'd5,   50, 150, 1'b0);
        run_phase(8'd255, 8'd255, 20, 200, 1'b0);
        run_phase(8'd20,  8'd40,  30, 150, 1'b0);
        run_phase(8'd2,   8'd11,  70, 150, 1'b1);

        // Let the last results come back, then allow for stray beats.
        s_tvalid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_seen)
            $display("SCOREBOARD MISMATCH");
        else
            $display("SCOREBOARD CLEAN");
        $finish;
    end

endmodule

// ===== key_matrix_ps2_transmitter.f =====
rtl/core/kmp_pkg.sv
rtl/core/kmp_ram.sv
rtl/core/kmp_front.sv
rtl/core/kmp_engine.sv
rtl/core/key_matrix_ps2_transmitter.sv
tb/tb_top.sv
